// File: sv/uqrs_pkg.sv
// Shared constants and types for the uniform mod-q rejection sampler.
// No dependencies; imported by uniform_mod_q_rejection_sampler_unit.
`timescale 1ns / 1ps

package uqrs_pkg;

  localparam int MAX_SAMPLES_DEF = 256;

  localparam int DATA_W   = 8;
  localparam int CNT_W    = 9;
  localparam int SAMPLE_W = 13;
  localparam int RES_W    = 20;
  localparam int FILL_W   = 5;

  localparam logic [SAMPLE_W-1:0] Q_MODE0 = 13'd3329;
  localparam logic [SAMPLE_W-1:0] Q_MODE1 = 13'd7681;
  localparam logic [FILL_W-1:0]   CAND13  = 5'd13;

  // register map (byte address bit 2 selects the register)
  localparam logic REG_MODE = 1'b0;

  localparam logic MODE_Q3329 = 1'b0;
  localparam logic MODE_Q7681 = 1'b1;

  localparam logic [1:0] PHASE_B0 = 2'd0;
  localparam logic [1:0] PHASE_B1 = 2'd1;
  localparam logic [1:0] PHASE_B2 = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [CNT_W-1:0]    count;
    logic                last;
    logic                met;
  } result_t;

endpackage

// File: sv/uniform_mod_q_rejection_sampler_unit.sv
// Uniform mod-q rejection sampler: byte stream in, accepted coefficients out.
// Byte results are registered into the queue; one byte per cycle unless stalled.
// Results leave one per cycle from a 4-entry queue while sample_stall is low;
// a byte is stalled while fewer than two queue entries are free.
// Synchronous active-high reset clears mode, stream state, count, limit, queue.
// Depends on uqrs_pkg.
`timescale 1ns / 1ps

module uniform_mod_q_rejection_sampler_unit
  import uqrs_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // APB config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // byte channel
  input  logic                byte_valid,
  output logic                byte_stall,
  input  logic [DATA_W-1:0]   data_byte,
  input  logic                first_byte,
  input  logic                last_byte,
  input  logic [CNT_W-1:0]    wanted_count,
  // sample channel
  output logic                sample_valid,
  input  logic                sample_stall,
  output logic [SAMPLE_W-1:0] sample,
  output logic [CNT_W-1:0]    sample_count,
  output logic                last_of_run,
  output logic                request_met
);

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // ---------------- config ----------------
  logic mode;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MODE);
  assign prdata = (paddr[2] == REG_MODE) ? {31'b0, mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_Q3329;
    end else if (cfg_wr) begin
      mode <= pwdata[0];
    end
  end

  // ---------------- stream state ----------------
  logic [RES_W-1:0]  reservoir, reservoir_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [1:0]        phase, phase_next;
  logic [CNT_W-1:0]  accepted, accepted_next;
  logic [CNT_W-1:0]  limit, limit_next;

  logic [QCNT_W-1:0] qcount;
  logic              take_byte;
  logic              take_sample;

  assign byte_stall  = (qcount > QCNT_W'(QDEPTH - 2));
  assign take_byte   = byte_valid && !byte_stall;

  // values after the first-byte clear
  logic [RES_W-1:0]  res_cur;
  logic [FILL_W-1:0] fill_cur;
  logic [1:0]        phase_cur;
  logic [CNT_W-1:0]  acc_cur;
  logic [CNT_W-1:0]  lim_cur;
  logic              active;

  logic [RES_W-1:0]    res_or;
  logic [FILL_W-1:0]   fill_sum;
  logic [SAMPLE_W-1:0] c0, c1;
  logic                have0, have1;
  logic                ok0, ok1;
  logic [CNT_W-1:0]    acc1, acc2;
  result_t             r0, r1;
  logic [1:0]          push_n;

  always_comb begin
    res_cur   = first_byte ? '0 : reservoir;
    fill_cur  = first_byte ? '0 : fill;
    phase_cur = first_byte ? PHASE_B0 : phase;
    acc_cur   = first_byte ? '0 : accepted;
    if (first_byte) begin
      lim_cur = (int'(wanted_count) > MAX_SAMPLES) ? CNT_W'(MAX_SAMPLES) : wanted_count;
    end else begin
      lim_cur = limit;
    end
    active = (acc_cur < lim_cur) || (lim_cur == '0);

    reservoir_next = res_cur;
    fill_next      = fill_cur;
    phase_next     = phase_cur;
    c0    = '0;
    c1    = '0;
    have0 = 1'b0;
    have1 = 1'b0;

    // fill never exceeds 12 between bytes, so 20 bits hold the OR
    res_or   = res_cur | (RES_W'(data_byte) << fill_cur[3:0]);
    fill_sum = {1'b0, fill_cur[3:0]} + FILL_W'(8);

    if (active) begin
      if (mode == MODE_Q3329) begin
        case (phase_cur)
          PHASE_B0: begin
            reservoir_next = RES_W'(data_byte);
            phase_next     = PHASE_B1;
          end
          PHASE_B1: begin
            reservoir_next = {4'b0, data_byte, res_cur[7:0]};
            phase_next     = PHASE_B2;
          end
          default: begin
            c0    = {1'b0, res_cur[11:0]};
            c1    = {1'b0, data_byte, res_cur[15:12]};
            have0 = 1'b1;
            have1 = 1'b1;
            reservoir_next = '0;
            phase_next     = PHASE_B0;
          end
        endcase
      end else begin
        if (fill_sum >= CAND13) begin
          c0    = res_or[SAMPLE_W-1:0];
          have0 = 1'b1;
          reservoir_next = res_or >> CAND13;
          fill_next      = fill_sum - CAND13;
        end else begin
          reservoir_next = res_or;
          fill_next      = fill_sum;
        end
      end
    end

    // rejection tests; second candidate sees the count after the first
    ok0  = have0 && (acc_cur < lim_cur)
           && (c0 < ((mode == MODE_Q3329) ? Q_MODE0 : Q_MODE1));
    acc1 = ok0 ? acc_cur + CNT_W'(1) : acc_cur;
    ok1  = have1 && (acc1 < lim_cur) && (c1 < Q_MODE0);
    acc2 = ok1 ? acc1 + CNT_W'(1) : acc1;
    accepted_next = acc2;
    limit_next    = lim_cur;

    r0 = '0;
    r1 = '0;
    if (ok0) begin
      r0.sample = c0;
      r0.count  = acc1;
      r0.last   = !ok1;
      r0.met    = (acc1 == lim_cur);
      if (ok1) begin
        r1.sample = c1;
        r1.count  = acc2;
        r1.last   = 1'b1;
        r1.met    = (acc2 == lim_cur);
      end
    end else if (ok1) begin
      r0.sample = c1;
      r0.count  = acc2;
      r0.last   = 1'b1;
      r0.met    = (acc2 == lim_cur);
    end
    push_n = {1'b0, ok0} + {1'b0, ok1};

    if (last_byte) begin
      reservoir_next = '0;
      fill_next      = '0;
      phase_next     = PHASE_B0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reservoir <= '0;
      fill      <= '0;
      phase     <= PHASE_B0;
      accepted  <= '0;
      limit     <= '0;
    end else if (cfg_wr) begin
      // mode change restarts byte alignment
      reservoir <= '0;
      fill      <= '0;
      phase     <= PHASE_B0;
    end else if (take_byte) begin
      reservoir <= reservoir_next;
      fill      <= fill_next;
      phase     <= phase_next;
      accepted  <= accepted_next;
      limit     <= limit_next;
    end
  end

  // ---------------- result queue ----------------
  result_t           queue [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [1:0]        push_eff;

  assign sample_valid = (qcount != '0);
  assign take_sample  = sample_valid && !sample_stall;
  assign push_eff     = take_byte ? push_n : 2'd0;

  assign sample       = queue[rd_ptr].sample;
  assign sample_count = queue[rd_ptr].count;
  assign last_of_run  = queue[rd_ptr].last;
  assign request_met  = queue[rd_ptr].met;

  always_ff @(posedge clk) begin
    if (push_eff != 2'd0) begin
      queue[wr_ptr] <= r0;
    end
    if (push_eff == 2'd2) begin
      queue[wr_ptr + PTR_W'(1)] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      qcount <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_eff);
      if (take_sample) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      qcount <= qcount + QCNT_W'(push_eff) - QCNT_W'(take_sample);
    end
  end

  // ---------------- assertions ----------------
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qcount <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_sample_below_q: assert property (@(posedge clk) disable iff (rst)
    sample_valid |-> (sample < Q_MODE1))
    else $error("sample not below modulus");

  // queued items may belong to an earlier buffer, so bound by the cap only
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    sample_valid |-> (sample_count != '0) && (int'(sample_count) <= MAX_SAMPLES))
    else $error("sample count out of range");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !sample_valid)
    else $error("result pending after reset");

endmodule
